// ===== hw/rtl/cpio_odc_pkg.sv =====
// Shared types, result codes and character tables for the odc archive parser.
package cpio_odc_pkg;

  // Header layout: magic, six-digit fields, eleven-digit mtime and file size
  localparam int          FieldW      = 18;
  localparam int          LongW       = 33;
  localparam int          NumSmall    = 6;
  localparam logic [6:0]  MagicLen    = 7'd6;
  localparam logic [6:0]  SmallDigits = 7'd6;
  localparam logic [6:0]  MtimeFirst  = 7'd48;
  localparam logic [6:0]  NameFirst   = 7'd59;
  localparam logic [6:0]  SizeFirst   = 7'd65;
  localparam logic [6:0]  HdrLast     = 7'd75;
  localparam logic [3:0]  TrailerLen  = 4'd10;

  // Result kinds
  localparam logic [2:0] KIND_NAME   = 3'd0;
  localparam logic [2:0] KIND_HEADER = 3'd1;
  localparam logic [2:0] KIND_DATA   = 3'd2;
  localparam logic [2:0] KIND_END    = 3'd3;
  localparam logic [2:0] KIND_ERROR  = 3'd4;
  localparam logic [2:0] KIND_TRUNC  = 3'd5;

  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_EOF  = 1'b1;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_NAME,
    PH_DATA,
    PH_SKIP,
    PH_STOP
  } phase_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] dev;
    logic [31:0] inode;
    logic [31:0] file_mode;
    logic [31:0] owner_id;
    logic [31:0] group_id;
    logic [31:0] link_count;
    logic [31:0] mod_time;
    logic [10:0] name_size;
    logic [32:0] file_size;
    logic [7:0]  byte_value;
    logic        last;
  } out_item_t;

  // Results produced by one item: count, then up to two items in order
  typedef struct packed {
    logic [1:0] n;
    out_item_t  first;
    out_item_t  second;
  } push_t;

  // Magic is 070707: even places '0', odd places '7'
  function automatic logic [7:0] magic_char(input logic [2:0] idx);
    return idx[0] ? 8'h37 : 8'h30;
  endfunction

  // Name of the closing entry, TRAILER!!!
  function automatic logic [7:0] trailer_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h54;
      4'd1:    c = 8'h52;
      4'd2:    c = 8'h41;
      4'd3:    c = 8'h49;
      4'd4:    c = 8'h4C;
      4'd5:    c = 8'h45;
      4'd6:    c = 8'h52;
      4'd7:    c = 8'h21;
      4'd8:    c = 8'h21;
      4'd9:    c = 8'h21;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Result item with all header fields zero
  function automatic out_item_t plain_item(input logic [2:0] kind, input logic [7:0] value,
                                           input logic last);
    out_item_t r;
    r            = '0;
    r.kind       = kind;
    r.byte_value = value;
    r.last       = last;
    return r;
  endfunction

endpackage

// ===== hw/rtl/cpio_odc_core.sv =====
// Parser state machine: header gathering, name and data echo, trailer detection.
module cpio_odc_core #(
  parameter int NAME_CAPACITY = 1024
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step,
  input  cpio_odc_pkg::in_item_t item,
  output cpio_odc_pkg::push_t    push,
  output logic                   stopped
);
  import cpio_odc_pkg::*;

  localparam int CapW = $clog2(NAME_CAPACITY + 1);
  localparam int PosW = (CapW > 7) ? CapW : 7;
  localparam logic [FieldW-1:0] Cap = FieldW'(NAME_CAPACITY);

  phase_t                phase, phase_next;
  logic [PosW-1:0]       position, position_next;
  logic [LongW-1:0]      data_left, data_left_next;
  logic [FieldW-1:0]     small_field [NumSmall];
  logic [FieldW-1:0]     small_field_next [NumSmall];
  logic [FieldW-1:0]     name_field, name_field_next;
  logic [LongW-1:0]      time_field, time_field_next;
  logic [LongW-1:0]      size_field, size_field_next;
  logic [NumSmall-1:0]   small_bad, small_bad_next;
  logic                  time_bad, time_bad_next;
  logic                  name_bad, name_bad_next;
  logic                  size_bad, size_bad_next;
  logic                  magic_bad, magic_bad_next;
  logic                  trailer_match, trailer_match_next;

  logic                  digit_ok;
  logic [2:0]            digit;
  logic [6:0]            hpos;
  logic [FieldW-1:0]     pos_inc;
  logic                  name_end;
  logic [7:0]            name_val;
  logic                  hdr_err;
  out_item_t             hdr_item;

  assign digit_ok = (item.data_byte[7:3] == 5'b00110);
  assign digit    = digit_ok ? item.data_byte[2:0] : 3'd0;
  assign hpos     = position[6:0];
  assign pos_inc  = FieldW'(position) + FieldW'(1);
  assign name_end = (pos_inc >= name_field);
  assign name_val = name_end ? 8'h00 : item.data_byte;
  assign stopped  = (phase == PH_STOP);

  // State registers: control cleared at reset, field registers are fully shifted before use
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HEADER;
      position      <= '0;
      data_left     <= '0;
      small_bad     <= '0;
      time_bad      <= 1'b0;
      name_bad      <= 1'b0;
      size_bad      <= 1'b0;
      magic_bad     <= 1'b0;
      trailer_match <= 1'b1;
    end else if (step) begin
      phase         <= phase_next;
      position      <= position_next;
      data_left     <= data_left_next;
      small_bad     <= small_bad_next;
      time_bad      <= time_bad_next;
      name_bad      <= name_bad_next;
      size_bad      <= size_bad_next;
      magic_bad     <= magic_bad_next;
      trailer_match <= trailer_match_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      small_field <= small_field_next;
      name_field  <= name_field_next;
      time_field  <= time_field_next;
      size_field  <= size_field_next;
    end
  end

  // Header result built from the values after the final header byte
  always_comb begin
    hdr_item            = '0;
    hdr_item.kind       = KIND_HEADER;
    hdr_item.dev        = small_bad_next[0] ? '1 : 32'(small_field_next[0]);
    hdr_item.inode      = small_bad_next[1] ? '1 : 32'(small_field_next[1]);
    hdr_item.file_mode  = small_bad_next[2] ? '1 : 32'(small_field_next[2]);
    hdr_item.owner_id   = small_bad_next[3] ? '1 : 32'(small_field_next[3]);
    hdr_item.group_id   = small_bad_next[4] ? '1 : 32'(small_field_next[4]);
    hdr_item.link_count = small_bad_next[5] ? '1 : 32'(small_field_next[5]);
    hdr_item.mod_time   = time_bad_next ? '1 : time_field_next[31:0];
    hdr_item.name_size  = name_field_next[10:0];
    hdr_item.file_size  = size_field_next;
    hdr_item.last       = 1'b1;
    hdr_err = magic_bad_next || name_bad_next || (name_field_next == '0) ||
              (name_field_next > Cap) || size_bad_next;
  end

  // Next state and results for the item in the input register
  always_comb begin
    phase_next         = phase;
    position_next      = position;
    data_left_next     = data_left;
    small_field_next   = small_field;
    name_field_next    = name_field;
    time_field_next    = time_field;
    size_field_next    = size_field;
    small_bad_next     = small_bad;
    time_bad_next      = time_bad;
    name_bad_next      = name_bad;
    size_bad_next      = size_bad;
    magic_bad_next     = magic_bad;
    trailer_match_next = trailer_match;
    push               = '0;

    if (step && phase != PH_STOP) begin
      if (item.mode == MODE_EOF) begin
        // End of input: clean end in the header phase, even part way through a header; truncated elsewhere
        push.n     = 2'd1;
        push.first = plain_item((phase == PH_HEADER) ? KIND_END : KIND_TRUNC, 8'h00, 1'b1);
        phase_next = PH_STOP;
      end else begin
        case (phase)
          PH_HEADER: begin
            // Check magic, shift digits into their field
            if (hpos < MagicLen) begin
              if (item.data_byte != magic_char(hpos[2:0])) magic_bad_next = 1'b1;
            end
            for (int i = 0; i < NumSmall; i++) begin
              if (hpos >= MagicLen + 7'(i) * SmallDigits &&
                  hpos < MagicLen + 7'(i + 1) * SmallDigits) begin
                small_field_next[i] = {small_field[i][FieldW-4:0], digit};
                if (!digit_ok) small_bad_next[i] = 1'b1;
              end
            end
            if (hpos >= MtimeFirst && hpos < NameFirst) begin
              time_field_next = {time_field[LongW-4:0], digit};
              if (!digit_ok) time_bad_next = 1'b1;
            end
            if (hpos >= NameFirst && hpos < SizeFirst) begin
              name_field_next = {name_field[FieldW-4:0], digit};
              if (!digit_ok) name_bad_next = 1'b1;
            end
            if (hpos >= SizeFirst) begin
              size_field_next = {size_field[LongW-4:0], digit};
              if (!digit_ok) size_bad_next = 1'b1;
            end
            position_next = position + PosW'(1);
            // Judge the header on its final byte
            if (hpos == HdrLast) begin
              push.n = 2'd1;
              if (hdr_err) begin
                push.first = plain_item(KIND_ERROR, 8'h00, 1'b1);
                phase_next = PH_STOP;
              end else begin
                push.first     = hdr_item;
                data_left_next = size_field_next;
                position_next  = '0;
                phase_next     = PH_NAME;
              end
            end
          end
          PH_NAME: begin
            // Echo name byte, force the last to zero, track the trailer name
            push.n     = 2'd1;
            push.first = plain_item(KIND_NAME, name_val, 1'b1);
            if (position < PosW'(TrailerLen)) begin
              if (name_val != trailer_char(position[3:0])) trailer_match_next = 1'b0;
            end else if (position == PosW'(TrailerLen)) begin
              if (name_val != 8'h00) trailer_match_next = 1'b0;
            end
            position_next = position + PosW'(1);
            if (name_end) begin
              if (trailer_match_next) begin
                if (data_left == '0) begin
                  push.n            = 2'd2;
                  push.first.last   = 1'b0;
                  push.second       = plain_item(KIND_END, 8'h00, 1'b1);
                  phase_next        = PH_STOP;
                end else begin
                  phase_next = PH_SKIP;
                end
              end else if (data_left == '0) begin
                phase_next         = PH_HEADER;
                position_next      = '0;
                small_bad_next     = '0;
                time_bad_next      = 1'b0;
                name_bad_next      = 1'b0;
                size_bad_next      = 1'b0;
                magic_bad_next     = 1'b0;
                trailer_match_next = 1'b1;
              end else begin
                phase_next = PH_DATA;
              end
            end
          end
          PH_DATA: begin
            // Echo data byte, return to header on the last one
            push.n         = 2'd1;
            push.first     = plain_item(KIND_DATA, item.data_byte, 1'b1);
            data_left_next = data_left - LongW'(1);
            if (data_left == LongW'(1)) begin
              phase_next         = PH_HEADER;
              position_next      = '0;
              small_bad_next     = '0;
              time_bad_next      = 1'b0;
              name_bad_next      = 1'b0;
              size_bad_next      = 1'b0;
              magic_bad_next     = 1'b0;
              trailer_match_next = 1'b1;
            end
          end
          PH_SKIP: begin
            // Drop trailer data, end after the last byte
            data_left_next = data_left - LongW'(1);
            if (data_left == LongW'(1)) begin
              push.n     = 2'd1;
              push.first = plain_item(KIND_END, 8'h00, 1'b1);
              phase_next = PH_STOP;
            end
          end
          default: begin
            phase_next = PH_STOP;
          end
        endcase
      end
    end
  end

endmodule

// ===== hw/rtl/cpio_odc_outq.sv =====
// Four-entry result queue taking up to two items per cycle.
module cpio_odc_outq (
  input  logic                    clk,
  input  logic                    rst,
  input  cpio_odc_pkg::push_t     push,
  output logic                    out_valid,
  input  logic                    out_stall,
  output cpio_odc_pkg::out_item_t out_item,
  output logic [2:0]              level
);
  import cpio_odc_pkg::*;

  out_item_t   mem [4];
  logic [1:0]  head, tail;
  logic [2:0]  count;
  logic        pop;

  assign out_valid = (count != 3'd0);
  assign out_item  = mem[head];
  assign pop       = out_valid && !out_stall;
  assign level     = count;

  // Store pushed items in order
  always_ff @(posedge clk) begin
    if (push.n != 2'd0) mem[tail] <= push.first;
    if (push.n == 2'd2) mem[tail + 2'd1] <= push.second;
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      tail  <= tail + push.n;
      head  <= head + 2'(pop);
      count <= count + 3'(push.n) - 3'(pop);
    end
  end

endmodule

// ===== hw/rtl/cpio_odc_stream_parser_top.sv =====
// Top level of the odc archive stream parser: input register, parser, result queue.
//
// Usage: feed archive bytes on the input channel (mode 0 with data_byte), then an
// item with mode 1 to mark end of input. Results leave on the output channel: an
// entry header, the name bytes (last one zero), the data bytes, and a final clean
// end, format error or truncation code. last marks the final result of each item.
// Both channels use valid/stall; an item moves when valid is high and stall low.
// Path: a taken item waits in the input register, then the parser step puts its
// results into the result queue. Throughput: one item per cycle; the
// parser steps only while the four-entry result queue has room for two results,
// so the sustained rate is set by how fast the receiver drains the queue.
// The closing entry of an archive may produce two results in one step.
// Stall: a stalled receiver holds the head result; the queue fills and in_stall
// rises while the input register is occupied. After an end, error or truncation
// result the block consumes and drops every item until reset.
// Reset: synchronous; empties the queue and input register and returns the parser
// to the start of a header.
module cpio_odc_stream_parser_top #(
  parameter int NAME_CAPACITY = 1024
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  cpio_odc_pkg::in_item_t  in_item,
  output logic                    out_valid,
  input  logic                    out_stall,
  output cpio_odc_pkg::out_item_t out_item
);
  import cpio_odc_pkg::*;

  logic        in_reg_valid;
  in_item_t    in_reg;
  logic        advance;
  logic        room;
  logic [2:0]  level;
  logic        stopped;
  push_t       push;

  assign room     = (level <= 3'd2);
  assign advance  = in_reg_valid && room;
  assign in_stall = in_reg_valid && !room;

  // Input register: load on accept, drop once the parser steps
  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_reg_valid <= 1'b1;
    end else if (advance) begin
      in_reg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) in_reg <= in_item;
  end

  cpio_odc_core #(
    .NAME_CAPACITY(NAME_CAPACITY)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .item    (in_reg),
    .push    (push),
    .stopped (stopped)
  );

  cpio_odc_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .level     (level)
  );

`ifndef SYNTH
  a_push_on_step: assert property (@(posedge clk) disable iff (rst)
    (push.n != 2'd0) |-> advance)
    else $error("results pushed without a parser step");

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    level <= 3'd4)
    else $error("result queue overfilled");

  a_silent_stop: assert property (@(posedge clk) disable iff (rst)
    stopped |-> (push.n == 2'd0))
    else $error("result produced after stop");

  a_pair_ends: assert property (@(posedge clk) disable iff (rst)
    (push.n == 2'd2) |-> (push.second.kind == KIND_END && push.second.last &&
                          !push.first.last))
    else $error("two-result step not closed by end marker");
`endif

endmodule

// ===== tb/cpio_odc_stream_parser_top_tb.sv =====
// Self-checking testbench for the odc archive stream parser top level.
module cpio_odc_stream_parser_top_tb;
  import cpio_odc_pkg::*;

  localparam int          NAME_CAP    = 1024;
  localparam int          HDR_BYTES   = int'(HdrLast) + 1;
  localparam int          CYCLE_LIMIT = 400000;
  localparam logic [7:0]  ASCII_0     = 8'h30;
  localparam logic [7:0]  ASCII_7     = 8'h37;
  localparam logic [79:0] TRAILER_NAME = "TRAILER!!!";
  // Characters just outside the octal digits, plus a few far away
  localparam logic [63:0] NON_DIGITS  = 64'h38_2F_00_FF_39_20_41_B7;

  typedef enum int {
    NAME_RANDOM,
    NAME_TRAILER,
    NAME_NEAR
  } name_style_t;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  // Archive parse state for prediction
  phase_t      arc_phase;
  int          arc_pos;
  logic [32:0] arc_left;
  logic [17:0] fld_small [8];
  logic [32:0] fld_time;
  logic [32:0] fld_size;
  logic [9:0]  fld_bad;
  logic        magic_wrong;
  logic        trailer_seen;

  out_item_t   pending_results [$];
  out_item_t   want;
  logic [7:0]  hdr_bytes [HDR_BYTES];
  bit          idle_on     = 1'b1;
  int          rx_hold     = 0;
  int          items_sent  = 0;
  int          mismatches  = 0;
  int          cycle_count = 0;

  cpio_odc_stream_parser_top #(
    .NAME_CAPACITY(NAME_CAP)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  always #4 clk = ~clk;

  // Return to the start of a header
  function automatic void clear_parse_state();
    for (int k = 0; k < 8; k++) fld_small[k] = '0;
    fld_time     = '0;
    fld_size     = '0;
    fld_bad      = '0;
    magic_wrong  = 1'b0;
    trailer_seen = 1'b1;
    arc_pos      = 0;
    arc_phase    = PH_HEADER;
  endfunction

  function automatic logic [31:0] small_value(int idx);
    return fld_bad[idx] ? 32'hFFFF_FFFF : 32'(fld_small[idx]);
  endfunction

  // Work out the results that one accepted item causes
  function automatic void parse_archive_byte(in_item_t it);
    out_item_t  r;
    logic [7:0] b;
    logic [7:0] v;
    logic [2:0] digit;
    logic       ok;
    logic       ns_bad;
    int         fld;
    b = it.data_byte;
    r = '0;
    if (arc_phase == PH_STOP) return;
    if (it.mode == MODE_EOF) begin
      r.kind = (arc_phase == PH_HEADER) ? KIND_END : KIND_TRUNC;
      r.last = 1'b1;
      pending_results.push_back(r);
      arc_phase = PH_STOP;
      return;
    end
    case (arc_phase)
      PH_HEADER: begin
        if (arc_pos < int'(MagicLen)) begin
          if (b != (arc_pos[0] ? ASCII_7 : ASCII_0)) magic_wrong = 1'b1;
        end else begin
          ok    = (b >= ASCII_0 && b <= ASCII_7);
          digit = ok ? 3'(b - ASCII_0) : 3'd0;
          if (arc_pos < int'(MtimeFirst)) begin
            fld = (arc_pos - int'(MagicLen)) / int'(SmallDigits);
            fld_small[fld] = {fld_small[fld][14:0], digit};
          end else if (arc_pos < int'(NameFirst)) begin
            fld = 7;
            fld_time = {fld_time[29:0], digit};
          end else if (arc_pos < int'(SizeFirst)) begin
            fld = 8;
            fld_small[7] = {fld_small[7][14:0], digit};
          end else begin
            fld = 9;
            fld_size = {fld_size[29:0], digit};
          end
          if (!ok) fld_bad[fld] = 1'b1;
        end
        arc_pos++;
        if (arc_pos < HDR_BYTES) return;
        // Judge the whole header on its last byte
        ns_bad = fld_bad[8] || fld_small[7] == 0 || fld_small[7] > NAME_CAP;
        r.last = 1'b1;
        if (magic_wrong || ns_bad || fld_bad[9]) begin
          r.kind = KIND_ERROR;
          pending_results.push_back(r);
          arc_phase = PH_STOP;
          return;
        end
        r.kind       = KIND_HEADER;
        r.dev        = small_value(0);
        r.inode      = small_value(1);
        r.file_mode  = small_value(2);
        r.owner_id   = small_value(3);
        r.group_id   = small_value(4);
        r.link_count = small_value(5);
        r.mod_time   = fld_bad[7] ? 32'hFFFF_FFFF : fld_time[31:0];
        r.name_size  = fld_small[7][10:0];
        r.file_size  = fld_size;
        pending_results.push_back(r);
        arc_left  = fld_size;
        arc_pos   = 0;
        arc_phase = PH_NAME;
      end
      PH_NAME: begin
        v = (arc_pos + 1 >= fld_small[7]) ? 8'h00 : b;
        if (arc_pos < 10) begin
          if (v != TRAILER_NAME[79 - 8 * arc_pos -: 8]) trailer_seen = 1'b0;
        end else if (arc_pos == 10 && v != 8'h00) begin
          trailer_seen = 1'b0;
        end
        r.kind       = KIND_NAME;
        r.byte_value = v;
        arc_pos++;
        if (arc_pos >= fld_small[7]) begin
          if (trailer_seen) begin
            if (arc_left == 0) begin
              pending_results.push_back(r);
              r = '0;
              r.kind    = KIND_END;
              arc_phase = PH_STOP;
            end else begin
              arc_phase = PH_SKIP;
            end
          end else if (arc_left == 0) begin
            clear_parse_state();
          end else begin
            arc_phase = PH_DATA;
          end
        end
        r.last = 1'b1;
        pending_results.push_back(r);
      end
      PH_DATA: begin
        r.kind       = KIND_DATA;
        r.byte_value = b;
        r.last       = 1'b1;
        pending_results.push_back(r);
        arc_left = arc_left - 1;
        if (arc_left == 0) clear_parse_state();
      end
      default: begin
        // Trailer data is dropped; the clean end follows its last byte
        arc_left = arc_left - 1;
        if (arc_left == 0) begin
          r.kind = KIND_END;
          r.last = 1'b1;
          pending_results.push_back(r);
          arc_phase = PH_STOP;
        end
      end
    endcase
  endfunction

  function automatic string describe(out_item_t r);
    return $sformatf({"kind=%0d dev=%h ino=%h mode=%h uid=%h gid=%h nlink=%h",
                      " mtime=%h ns=%0d fs=%h byte=%h last=%b"},
                     r.kind, r.dev, r.inode, r.file_mode, r.owner_id, r.group_id,
                     r.link_count, r.mod_time, r.name_size, r.file_size,
                     r.byte_value, r.last);
  endfunction

  // Header image helpers
  function automatic void put_octal(int start_at, int digits, logic [32:0] val);
    for (int k = 0; k < digits; k++)
      hdr_bytes[start_at + digits - 1 - k] = ASCII_0 + 8'(val[3 * k +: 3]);
  endfunction

  function automatic logic [7:0] non_digit();
    logic [7:0] c;
    do c = 8'($urandom); while (c >= ASCII_0 && c <= ASCII_7);
    return c;
  endfunction

  function automatic void spoil_digit(int start_at, int len);
    hdr_bytes[start_at + $urandom_range(0, len - 1)] = non_digit();
  endfunction

  function automatic void fill_header(int ns, logic [32:0] fs);
    for (int k = 0; k < int'(MagicLen); k++) hdr_bytes[k] = k[0] ? ASCII_7 : ASCII_0;
    for (int f = 0; f < 7; f++)
      put_octal(int'(MagicLen) + 6 * f, 6, 33'($urandom_range(0, 18'h3FFFF)));
    put_octal(int'(MtimeFirst), 11, {1'($urandom), 32'($urandom)});
    put_octal(int'(NameFirst), 6, 33'(ns));
    put_octal(int'(SizeFirst), 11, fs);
  endfunction

  // Drive one item, hold it until taken, then predict its results
  task automatic send_item(input logic mode, input logic [7:0] value);
    in_item_t it;
    it.mode      = mode;
    it.data_byte = value;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_item  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    items_sent++;
    parse_archive_byte(it);
    @(negedge clk);
  endtask

  task automatic send_header(input int count);
    for (int k = 0; k < count; k++) send_item(MODE_BYTE, hdr_bytes[k]);
  endtask

  task automatic send_body(input int name_len, input int data_len, input name_style_t style,
                           input int miss);
    logic [7:0] c;
    for (int i = 0; i < name_len; i++) begin
      c = 8'($urandom);
      if (style != NAME_RANDOM) begin
        if (i < 10) c = TRAILER_NAME[79 - 8 * i -: 8];
        else if (i == 10) c = 8'h00;
        if (style == NAME_NEAR && i == miss)
          c = (i < 10) ? c ^ 8'h20 : 8'($urandom_range(1, 255));
      end
      send_item(MODE_BYTE, c);
    end
    for (int i = 0; i < data_len; i++) send_item(MODE_BYTE, 8'($urandom));
  endtask

  // Zero and full-scale fields, wide mtime, and bad digits in every plain field
  task automatic test_field_extremes();
    fill_header(1, 0);
    for (int f = 0; f < 7; f++) put_octal(int'(MagicLen) + 6 * f, 6, '0);
    put_octal(int'(MtimeFirst), 11, 33'h1_0000_0000);
    send_header(HDR_BYTES);
    send_body(1, 0, NAME_RANDOM, 0);

    fill_header(2, 1);
    for (int f = 0; f < 7; f++) put_octal(int'(MagicLen) + 6 * f, 6, 33'h3FFFF);
    put_octal(int'(MtimeFirst), 11, 33'h1_FFFF_FFFF);
    send_header(HDR_BYTES);
    send_body(2, 1, NAME_RANDOM, 0);

    fill_header(3, 3);
    for (int f = 0; f < 7; f++)
      hdr_bytes[int'(MagicLen) + 6 * f + (f % 6)] = NON_DIGITS[63 - 8 * f -: 8];
    hdr_bytes[int'(NameFirst) - 1] = NON_DIGITS[7:0];
    send_header(HDR_BYTES);
    send_body(3, 3, NAME_RANDOM, 0);

    // Data byte extremes
    fill_header(2, 4);
    send_header(HDR_BYTES);
    send_body(2, 0, NAME_RANDOM, 0);
    send_item(MODE_BYTE, 8'h00);
    send_item(MODE_BYTE, 8'hFF);
    send_item(MODE_BYTE, 8'h55);
    send_item(MODE_BYTE, 8'hAA);
  endtask

  // Longest name and names that almost spell the trailer
  task automatic test_name_edges();
    fill_header(NAME_CAP, 0);
    send_header(HDR_BYTES);
    send_body(NAME_CAP, 0, NAME_RANDOM, 0);

    fill_header(12, 1);
    send_header(HDR_BYTES);
    send_body(12, 1, NAME_NEAR, 10);

    fill_header(10, 0);
    send_header(HDR_BYTES);
    send_body(10, 0, NAME_TRAILER, 0);

    fill_header(11, 2);
    send_header(HDR_BYTES);
    send_body(11, 2, NAME_NEAR, 3);
  endtask

  // Well-formed entries with random content and stray non-digits in plain fields
  task automatic test_random_entries();
    int          start_count;
    int          ns;
    int          fs;
    int          miss;
    name_style_t style;
    start_count = items_sent;
    while (items_sent - start_count < 750) begin
      idle_on = ($urandom_range(0, 3) != 0);
      ns = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
      if ($urandom_range(0, 3) == 0) fs = 0;
      else if ($urandom_range(0, 9) == 0) fs = $urandom_range(9, 40);
      else fs = $urandom_range(1, 8);
      fill_header(ns, 33'(fs));
      if ($urandom_range(0, 2) == 0)
        repeat ($urandom_range(1, 3)) spoil_digit(int'(MagicLen), int'(NameFirst) - 6);
      style = NAME_RANDOM;
      miss  = 0;
      if (ns >= 11 && $urandom_range(0, 4) == 0) begin
        style = NAME_NEAR;
        miss  = (ns == 11) ? $urandom_range(0, 9) : $urandom_range(0, 10);
      end
      send_header(HDR_BYTES);
      send_body(ns, fs, style, miss);
    end
  endtask

  // Close the stream one way, then check that later items are dropped
  task automatic test_stream_end();
    int ns;
    int fs;
    idle_on = 1'b0;
    ns = $urandom_range(0, 1) ? 11 : $urandom_range(12, 20);
    fs = $urandom_range(2, 20);
    case ($urandom_range(0, 11))
      0: send_item(MODE_EOF, 8'($urandom));
      1: begin
        fill_header(1, 0);
        send_header($urandom_range(1, HDR_BYTES - 1));
        send_item(MODE_EOF, 8'($urandom));
      end
      2: begin
        fill_header(4, 2);
        ns = $urandom_range(0, int'(MagicLen) - 1);
        hdr_bytes[ns] = hdr_bytes[ns] + 8'($urandom_range(1, 255));
        send_header(HDR_BYTES);
      end
      3: begin
        fill_header(4, 2);
        spoil_digit(int'(NameFirst), 6);
        send_header(HDR_BYTES);
      end
      4: begin
        fill_header(0, 2);
        send_header(HDR_BYTES);
      end
      5: begin
        fill_header($urandom_range(0, 1) ? NAME_CAP + 1 : $urandom_range(NAME_CAP + 1, 18'h3FFFF),
                    2);
        send_header(HDR_BYTES);
      end
      6: begin
        fill_header(4, 2);
        spoil_digit(int'(SizeFirst), 11);
        send_header(HDR_BYTES);
      end
      7: begin
        fill_header(ns, 3);
        send_header(HDR_BYTES);
        send_body($urandom_range(0, ns - 1), 0, NAME_RANDOM, 0);
        send_item(MODE_EOF, 8'($urandom));
      end
      8: begin
        ns = $urandom_range(1, 8);
        fill_header(ns, $urandom_range(0, 1) ? 33'h1_FFFF_FFFF : 33'(fs));
        send_header(HDR_BYTES);
        send_body(ns, $urandom_range(0, fs - 1), NAME_RANDOM, 0);
        send_item(MODE_EOF, 8'($urandom));
      end
      9: begin
        fill_header(ns, 0);
        send_header(HDR_BYTES);
        send_body(ns, 0, NAME_TRAILER, 0);
      end
      10: begin
        fill_header(ns, 33'(fs));
        send_header(HDR_BYTES);
        send_body(ns, fs, NAME_TRAILER, 0);
      end
      default: begin
        fill_header(ns, 33'(fs));
        send_header(HDR_BYTES);
        if ($urandom_range(0, 1)) send_body($urandom_range(0, ns - 1), 0, NAME_TRAILER, 0);
        else send_body(ns, $urandom_range(0, fs - 1), NAME_TRAILER, 0);
        send_item(MODE_EOF, 8'($urandom));
      end
    endcase
    repeat (6) send_item(1'($urandom_range(0, 1)), 8'($urandom));
  endtask

  // Receiver stalls in random bursts
  always @(negedge clk) begin
    if (rx_hold == 0 && idle_on && $urandom_range(0, 7) == 0) rx_hold = $urandom_range(1, 6);
    if (rx_hold != 0) begin
      out_stall <= 1'b1;
      rx_hold--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Check each taken result against the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result %s", describe(out_item));
      end else begin
        want = pending_results.pop_front();
        if (out_item !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("ERROR: result mismatch");
            $display("  expected %s", describe(want));
            $display("  actual   %s", describe(out_item));
          end
        end
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("ERROR: timeout with %0d results outstanding", pending_results.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    clear_parse_state();
    arc_left = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_field_extremes();
    test_name_edges();
    test_random_entries();
    test_stream_end();
    in_valid <= 1'b0;
    // Drain outstanding results, then watch for strays
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
